FILE: rtl/core/nfcs_pkg.sv
// ----------------------------------------------------------------------------
// nfcs_pkg
// Shared types, codes and the bus cycle table of the nor flash command
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcs_pkg;

  localparam int ADDRESS_BITS_DEFAULT = 24;
  localparam int BUS_ADDR_BITS        = 24;
  localparam int DATA_BITS            = 16;
  localparam int DIE_BITS             = 8;
  localparam int COUNT_BITS           = 22;
  localparam int CFG_DATA_BITS        = 22;
  localparam int CFG_INDEX_BITS       = 2;
  localparam int STEP_BITS            = 3;
  localparam int LOW_BITS             = 12;
  localparam int BUFFER_WORDS         = 32;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [COUNT_BITS-1:0] TIMEOUT_DEFAULT = 22'h200000;

  // flash command words
  localparam logic [DATA_BITS-1:0] CMD_UNLOCK1      = 16'h00AA;
  localparam logic [DATA_BITS-1:0] CMD_UNLOCK2      = 16'h0055;
  localparam logic [DATA_BITS-1:0] CMD_PROGRAM      = 16'h00A0;
  localparam logic [DATA_BITS-1:0] CMD_ERASE_SETUP  = 16'h0080;
  localparam logic [DATA_BITS-1:0] CMD_SECTOR_ERASE = 16'h0030;
  localparam logic [DATA_BITS-1:0] CMD_CHIP_ERASE   = 16'h0010;
  localparam logic [DATA_BITS-1:0] CMD_BYPASS_ENTER = 16'h0020;
  localparam logic [DATA_BITS-1:0] CMD_BUFFER_LOAD  = 16'h0025;
  localparam logic [DATA_BITS-1:0] CMD_BUFFER_SHIP  = 16'h0029;
  localparam logic [DATA_BITS-1:0] CMD_AUTOSELECT   = 16'h0090;
  localparam logic [DATA_BITS-1:0] CMD_BYPASS_EXIT2 = 16'h0000;
  localparam logic [DATA_BITS-1:0] BUFFER_COUNT     = 16'(BUFFER_WORDS - 1);

  localparam logic [LOW_BITS-1:0] UNLOCK_ADDR1 = 12'h555;
  localparam logic [LOW_BITS-1:0] UNLOCK_ADDR2 = 12'h2AA;
  localparam logic [LOW_BITS-1:0] ID_ADDR0     = 12'h000;
  localparam logic [LOW_BITS-1:0] ID_ADDR1     = 12'h001;
  localparam logic [LOW_BITS-1:0] ID_ADDR2     = 12'h00E;
  localparam logic [LOW_BITS-1:0] ID_ADDR3     = 12'h00F;

  typedef enum logic [4:0] {
    OP_SET_ADDR     = 5'd0,
    OP_READ         = 5'd1,
    OP_READ_NEXT    = 5'd2,
    OP_RAW_WRITE    = 5'd3,
    OP_SECTOR_ERASE = 5'd4,
    OP_CHIP_ERASE   = 5'd5,
    OP_PROGRAM      = 5'd6,
    OP_BYP_ENTER    = 5'd7,
    OP_BYP_PROGRAM  = 5'd8,
    OP_BYP_EXIT     = 5'd9,
    OP_BUF_BEGIN    = 5'd10,
    OP_BUF_DATA     = 5'd11,
    OP_BUF_COMMIT   = 5'd12,
    OP_IDENTIFY     = 5'd13,
    OP_RESET        = 5'd14,
    OP_READY_TICK   = 5'd15,
    OP_FINISH       = 5'd16
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DIE_OFFSET    = 2'd0,
    CFG_AUTO_INC      = 2'd1,
    CFG_READY_TIMEOUT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    WAIT_IDLE       = 2'd0,
    WAIT_SHORT      = 2'd1,
    WAIT_LONG       = 2'd2,
    WAIT_LONG_RESET = 2'd3
  } wait_mode_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_STATUS = 2'd3
  } cycle_kind_t;

  typedef enum logic [3:0] {
    SEQ_READ,
    SEQ_RAW,
    SEQ_SECTOR,
    SEQ_CHIP,
    SEQ_PROGRAM,
    SEQ_BYP_ENTER,
    SEQ_BYP_PROGRAM,
    SEQ_BYP_EXIT,
    SEQ_BUF_BEGIN,
    SEQ_BUF_DATA,
    SEQ_COMMIT,
    SEQ_IDENTIFY,
    SEQ_RESET,
    SEQ_STATUS
  } seq_t;

  typedef enum logic [1:0] {
    ASEL_JOB,
    ASEL_DIE,
    ASEL_ZERO_TOP,
    ASEL_NONE
  } addr_sel_t;

  typedef struct packed {
    seq_t                 seq;
    logic [DATA_BITS-1:0] word;
    logic [DIE_BITS-1:0]  die;
    logic                 status;
  } job_t;

  typedef struct packed {
    cycle_kind_t          kind;
    addr_sel_t            asel;
    logic [LOW_BITS-1:0]  low;
    logic [DATA_BITS-1:0] data;
    logic                 last;
  } bus_step_t;

  function automatic bus_step_t mk_step(cycle_kind_t k, addr_sel_t a,
                                        logic [LOW_BITS-1:0] lo,
                                        logic [DATA_BITS-1:0] d, logic l);
    bus_step_t s;
    s.kind = k;
    s.asel = a;
    s.low  = lo;
    s.data = d;
    s.last = l;
    return s;
  endfunction

  // bus cycle number step of a queued job
  function automatic bus_step_t step_decode(job_t job, logic [STEP_BITS-1:0] step);
    bus_step_t s;
    s = mk_step(KIND_RESET, ASEL_NONE, '0, '0, 1'b1);
    case (job.seq)
      SEQ_READ: s = mk_step(KIND_READ, ASEL_JOB, '0, '0, 1'b1);
      SEQ_RAW, SEQ_BUF_DATA: s = mk_step(KIND_WRITE, ASEL_JOB, '0, job.word, 1'b1);
      SEQ_SECTOR, SEQ_CHIP: begin
        case (step)
          3'd0: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_UNLOCK1, 1'b0);
          3'd1: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR2, CMD_UNLOCK2, 1'b0);
          3'd2: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_ERASE_SETUP, 1'b0);
          3'd3: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_UNLOCK1, 1'b0);
          3'd4: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR2, CMD_UNLOCK2, 1'b0);
          default: begin
            if (job.seq == SEQ_SECTOR) begin
              s = mk_step(KIND_WRITE, ASEL_JOB, '0, CMD_SECTOR_ERASE, 1'b1);
            end else begin
              s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_CHIP_ERASE, 1'b1);
            end
          end
        endcase
      end
      SEQ_PROGRAM: begin
        case (step)
          3'd0: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_UNLOCK1, 1'b0);
          3'd1: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR2, CMD_UNLOCK2, 1'b0);
          3'd2: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_PROGRAM, 1'b0);
          default: s = mk_step(KIND_WRITE, ASEL_JOB, '0, job.word, 1'b1);
        endcase
      end
      SEQ_BYP_ENTER: begin
        case (step)
          3'd0: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_UNLOCK1, 1'b0);
          3'd1: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR2, CMD_UNLOCK2, 1'b0);
          default: s = mk_step(KIND_WRITE, ASEL_DIE, UNLOCK_ADDR1, CMD_BYPASS_ENTER, 1'b1);
        endcase
      end
      SEQ_BYP_PROGRAM: begin
        case (step)
          3'd0: s = mk_step(KIND_WRITE, ASEL_JOB, '0, CMD_PROGRAM, 1'b0);
          default: s = mk_step(KIND_WRITE, ASEL_JOB, '0, job.word, 1'b1);
        endcase
      end
      SEQ_BYP_EXIT: begin
        case (step)
          3'd0: s = mk_step(KIND_WRITE, ASEL_JOB, '0, CMD_AUTOSELECT, 1'b0);
          default: s = mk_step(KIND_WRITE, ASEL_JOB, '0, CMD_BYPASS_EXIT2, 1'b1);
        endcase
      end
      SEQ_BUF_BEGIN: begin
        case (step)
          3'd0: s = mk_step(KIND_WRITE, ASEL_ZERO_TOP, UNLOCK_ADDR1, CMD_UNLOCK1, 1'b0);
          3'd1: s = mk_step(KIND_WRITE, ASEL_ZERO_TOP, UNLOCK_ADDR2, CMD_UNLOCK2, 1'b0);
          3'd2: s = mk_step(KIND_WRITE, ASEL_JOB, '0, CMD_BUFFER_LOAD, 1'b0);
          default: s = mk_step(KIND_WRITE, ASEL_JOB, '0, BUFFER_COUNT, 1'b1);
        endcase
      end
      SEQ_COMMIT: s = mk_step(KIND_WRITE, ASEL_JOB, '0, CMD_BUFFER_SHIP, 1'b1);
      SEQ_IDENTIFY: begin
        case (step)
          3'd0: s = mk_step(KIND_WRITE, ASEL_ZERO_TOP, UNLOCK_ADDR1, CMD_UNLOCK1, 1'b0);
          3'd1: s = mk_step(KIND_WRITE, ASEL_ZERO_TOP, UNLOCK_ADDR2, CMD_UNLOCK2, 1'b0);
          3'd2: s = mk_step(KIND_WRITE, ASEL_ZERO_TOP, UNLOCK_ADDR1, CMD_AUTOSELECT, 1'b0);
          3'd3: s = mk_step(KIND_READ, ASEL_ZERO_TOP, ID_ADDR0, '0, 1'b0);
          3'd4: s = mk_step(KIND_READ, ASEL_ZERO_TOP, ID_ADDR1, '0, 1'b0);
          3'd5: s = mk_step(KIND_READ, ASEL_ZERO_TOP, ID_ADDR2, '0, 1'b0);
          3'd6: s = mk_step(KIND_READ, ASEL_ZERO_TOP, ID_ADDR3, '0, 1'b0);
          default: s = mk_step(KIND_RESET, ASEL_NONE, '0, '0, 1'b1);
        endcase
      end
      SEQ_RESET: s = mk_step(KIND_RESET, ASEL_NONE, '0, '0, 1'b1);
      SEQ_STATUS: s = mk_step(KIND_STATUS, ASEL_NONE, '0, '0, 1'b1);
      default: s = mk_step(KIND_RESET, ASEL_NONE, '0, '0, 1'b1);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer
// Command sequencer for a 16-bit parallel nor flash with the amd command set.
// ----------------------------------------------------------------------------
// Each accepted command produces zero to eight results, one per clock unless
// stalled: write strobes, read strobes, reset pulses and status reports, the
// final one marked by last. The front end takes one command per clock while
// the queue has room and updates the address, wait and timeout state at once;
// commands that cause bus cycles go into a two-entry job queue, and the back
// end emits one result per clock, unless out_ready stalls it, from the job
// at the queue head into the output register. A command thus occupies the
// back end until all of its results are out (one for a read or a write, eight
// for identify). There is no start-up pass after reset.
`default_nettype none

module nor_flash_command_sequencer import nfcs_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [4:0]                opcode,
  input  wire logic [BUS_ADDR_BITS-1:0]  target_address,
  input  wire logic [DATA_BITS-1:0]      write_word,
  input  wire logic                      ready_level,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [1:0]                     cycle_kind,
  output logic [BUS_ADDR_BITS-1:0]       bus_address,
  output logic [DATA_BITS-1:0]           bus_data,
  output logic                           status,
  output logic                           last,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int QW = $bits(job_t) + ADDRESS_BITS;

  logic                    push;
  job_t                    push_job;
  logic [ADDRESS_BITS-1:0] push_addr;
  logic                    q_full;
  logic                    q_valid;
  logic [QW-1:0]           q_data;
  logic                    q_pop;
  job_t                    head_job;
  logic [ADDRESS_BITS-1:0] head_addr;

  nfcs_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .target_address (target_address),
    .write_word     (write_word),
    .ready_level    (ready_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .job_full       (q_full),
    .job_valid      (push),
    .job            (push_job),
    .job_addr       (push_addr)
  );

  nfcs_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_job, push_addr}),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  assign {head_job, head_addr} = q_data;

  nfcs_back #(.ADDRESS_BITS(ADDRESS_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_valid),
    .job         (head_job),
    .job_addr    (head_addr),
    .job_pop     (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cycle_kind  (cycle_kind),
    .bus_address (bus_address),
    .bus_data    (bus_data),
    .status      (status),
    .last        (last)
  );

endmodule

`default_nettype wire

FILE: rtl/core/nfcs_front.sv
// ----------------------------------------------------------------------------
// nfcs_front
// Takes host commands, keeps the address, wait and timeout state, and hands
// a job for each command that causes bus cycles to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_front import nfcs_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [4:0]                opcode,
  input  wire logic [BUS_ADDR_BITS-1:0]  target_address,
  input  wire logic [DATA_BITS-1:0]      write_word,
  input  wire logic                      ready_level,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      job_full,
  output logic                           job_valid,
  output job_t                           job,
  output logic [ADDRESS_BITS-1:0]        job_addr
);

  logic [DIE_BITS-1:0]     die_offset;
  logic                    auto_increment;
  logic [COUNT_BITS-1:0]   ready_timeout;

  logic [ADDRESS_BITS-1:0] current_address, current_address_next;
  logic [ADDRESS_BITS-1:0] buffer_start, buffer_start_next;
  wait_mode_t              wait_mode, wait_mode_next;
  logic [COUNT_BITS-1:0]   wait_count, wait_count_next;
  logic                    timed_out, timed_out_next;

  logic                    accept;
  op_t                     op;
  logic [ADDRESS_BITS-1:0] addr_inc;
  logic [COUNT_BITS-1:0]   count_inc;

  assign in_ready  = !job_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign op        = op_t'(opcode);
  assign addr_inc  = current_address + 1'b1;
  assign count_inc = wait_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      die_offset     <= '0;
      auto_increment <= 1'b0;
      ready_timeout  <= TIMEOUT_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_DIE_OFFSET:    die_offset     <= cfg_data[DIE_BITS-1:0];
        CFG_AUTO_INC:      auto_increment <= cfg_data[0];
        CFG_READY_TIMEOUT: ready_timeout  <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_mode       <= WAIT_IDLE;
      current_address <= '0;
      buffer_start    <= '0;
      wait_count      <= '0;
      timed_out       <= 1'b0;
    end else begin
      wait_mode       <= wait_mode_next;
      current_address <= current_address_next;
      buffer_start    <= buffer_start_next;
      wait_count      <= wait_count_next;
      timed_out       <= timed_out_next;
    end
  end

  always_comb begin
    wait_mode_next       = wait_mode;
    current_address_next = current_address;
    buffer_start_next    = buffer_start;
    wait_count_next      = wait_count;
    timed_out_next       = timed_out;
    job_valid            = 1'b0;
    job.seq              = SEQ_RESET;
    job.word             = write_word;
    job.die              = die_offset;
    job.status           = timed_out;
    job_addr             = current_address;

    if (accept) begin
      if (op == OP_READY_TICK) begin
        case (wait_mode)
          WAIT_SHORT: begin
            if (ready_level) begin
              wait_mode_next = WAIT_IDLE;
            end else begin
              wait_count_next = count_inc;
              if (count_inc >= ready_timeout) begin
                timed_out_next = 1'b1;
                wait_mode_next = WAIT_IDLE;
              end
            end
          end
          WAIT_LONG: begin
            if (ready_level) wait_mode_next = WAIT_IDLE;
          end
          WAIT_LONG_RESET: begin
            if (ready_level) begin
              wait_mode_next = WAIT_IDLE;
              job_valid      = 1'b1;
              job.seq        = SEQ_RESET;
            end
          end
          default: ;
        endcase
      end else if (wait_mode == WAIT_IDLE) begin
        case (op)
          OP_SET_ADDR: current_address_next = ADDRESS_BITS'(target_address);
          OP_READ: begin
            job_valid = 1'b1;
            job.seq   = SEQ_READ;
          end
          OP_READ_NEXT: begin
            job_valid            = 1'b1;
            job.seq              = SEQ_READ;
            current_address_next = addr_inc;
          end
          OP_RAW_WRITE: begin
            job_valid = 1'b1;
            job.seq   = SEQ_RAW;
            if (auto_increment) current_address_next = addr_inc;
          end
          OP_SECTOR_ERASE: begin
            job_valid       = 1'b1;
            job.seq         = SEQ_SECTOR;
            wait_mode_next  = WAIT_LONG;
            wait_count_next = '0;
          end
          OP_CHIP_ERASE: begin
            job_valid       = 1'b1;
            job.seq         = SEQ_CHIP;
            wait_mode_next  = WAIT_LONG_RESET;
            wait_count_next = '0;
          end
          OP_PROGRAM, OP_BYP_PROGRAM: begin
            if (!timed_out) begin
              job_valid            = 1'b1;
              job.seq              = (op == OP_PROGRAM) ? SEQ_PROGRAM : SEQ_BYP_PROGRAM;
              current_address_next = addr_inc;
              wait_mode_next       = WAIT_SHORT;
              wait_count_next      = '0;
            end
          end
          OP_BYP_ENTER: begin
            job_valid = 1'b1;
            job.seq   = SEQ_BYP_ENTER;
          end
          OP_BYP_EXIT: begin
            job_valid = 1'b1;
            job.seq   = SEQ_BYP_EXIT;
          end
          OP_BUF_BEGIN: begin
            job_valid         = 1'b1;
            job.seq           = SEQ_BUF_BEGIN;
            buffer_start_next = current_address;
          end
          OP_BUF_DATA: begin
            if (!timed_out) begin
              job_valid            = 1'b1;
              job.seq              = SEQ_BUF_DATA;
              current_address_next = addr_inc;
            end
          end
          OP_BUF_COMMIT: begin
            if (!timed_out) begin
              job_valid       = 1'b1;
              job.seq         = SEQ_COMMIT;
              job_addr        = buffer_start;
              wait_mode_next  = WAIT_SHORT;
              wait_count_next = '0;
            end
          end
          OP_IDENTIFY: begin
            job_valid = 1'b1;
            job.seq   = SEQ_IDENTIFY;
          end
          OP_RESET: begin
            job_valid = 1'b1;
            job.seq   = SEQ_RESET;
          end
          OP_FINISH: begin
            job_valid      = 1'b1;
            job.seq        = SEQ_STATUS;
            timed_out_next = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // a job is only ever queued by an accepted command
  a_job_needs_accept: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> accept)
    else $error("job queued without an accepted command");

  // a command that starts a wait always hands a job to the back end
  a_wait_start_queues: assert property (@(posedge clk) disable iff (rst)
    (wait_mode == WAIT_IDLE && wait_mode_next != WAIT_IDLE) |-> job_valid)
    else $error("wait started without bus cycles");

endmodule

`default_nettype wire

FILE: rtl/core/nfcs_queue.sv
// ----------------------------------------------------------------------------
// nfcs_queue
// Two-entry job queue between the command front end and the bus cycle
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_queue import nfcs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [COUNT_W-1:0]  count;

  assign full       = (count == COUNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/core/nfcs_back.sv
// ----------------------------------------------------------------------------
// nfcs_back
// Walks the bus cycles of the job at the head of the queue, one per clock
// when the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_back import nfcs_pkg::*; #(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     job_valid,
  input  job_t                          job,
  input  wire logic [ADDRESS_BITS-1:0]  job_addr,
  output logic                          job_pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    cycle_kind,
  output logic [BUS_ADDR_BITS-1:0]      bus_address,
  output logic [DATA_BITS-1:0]          bus_data,
  output logic                          status,
  output logic                          last
);

  logic [STEP_BITS-1:0]    step;
  bus_step_t               cur;
  logic                    load;
  logic [ADDRESS_BITS-1:0] addr;
  logic [31:0]             addr_wide;

  assign cur     = step_decode(job, step);
  assign load    = job_valid && (!out_valid || out_ready);
  assign job_pop = load && cur.last;

  always_comb begin
    case (cur.asel)
      ASEL_JOB:      addr = job_addr;
      ASEL_DIE:      addr = (ADDRESS_BITS'(job.die) << (ADDRESS_BITS - DIE_BITS))
                            | ADDRESS_BITS'(cur.low);
      ASEL_ZERO_TOP: addr = ADDRESS_BITS'(cur.low);
      default:       addr = '0;
    endcase
  end

  assign addr_wide = 32'(addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      step      <= cur.last ? '0 : step + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cycle_kind  <= cur.kind;
      bus_address <= addr_wide[BUS_ADDR_BITS-1:0];
      bus_data    <= cur.data;
      status      <= (cur.kind == KIND_STATUS) && job.status;
      last        <= cur.last;
    end
  end

  // only a status report carries a status bit
  a_status_only_in_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cycle_kind != KIND_STATUS) |-> !status)
    else $error("status bit on a bus cycle");

endmodule

`default_nettype wire
